// ----- rtl/rs_parity_vector_encoder_core_assert.svh -----
// assertion macros for the encoder rtl
// no dependencies; included by the core module, which checks its own logic
`ifndef RS_PARITY_VECTOR_ENCODER_CORE_ASSERT_SVH
`define RS_PARITY_VECTOR_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
	else $error("check failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
	else $error("check failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// ----- rtl/rspve_pkg.sv -----
// shared types, constants and gf(256) helpers for the parity vector encoder
// no dependencies
`default_nettype none
package rspve_pkg;

	localparam int DEF_MAX_PARITY = 16;
	localparam int DEF_MAX_VECTOR = 512;

	localparam int POS_W  = 9;
	localparam int SEL_W  = 4;
	localparam int BYTE_W = 8;
	localparam int CFG_W  = 10;
	localparam int IN_TDATA_W = 24;

	// register indexes
	localparam logic REG_NUM_PARITY    = 1'b0;
	localparam logic REG_VECTOR_LENGTH = 1'b1;

	// request kinds carried in tuser
	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ENCODE,
		OP_READ_CLEAR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [SEL_W-1:0] sel;
		logic [7:0]       fb;
		logic [7:0]       root;
		logic             gen_init;
		logic             gen_step;
	} cell_ctl_t;

	// gf(256) multiply, field polynomial 0x11d
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] r;
		x = a;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1d : 8'h00);
		end
		return r;
	endfunction

	// multiply by alpha
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1d : 8'h00);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rs_parity_vector_encoder_core.sv -----
// Reed-Solomon GF(256) parity vector encoder: MAX_PARITY cells in a row, one per parity
// vector, each with its own byte row and generator coefficient; an encode request shifts
// parity bytes one cell down at its byte position. Each request is a row read, then update
// and write back in all cells at once, and no new request is taken until it is done.
// After reset every row address is swept to zero before the first request is taken. A
// num_parity write rebuilds the generator, one root per cycle down the cell row; requests
// wait meanwhile. Results leave through an output register.
// depends on rspve_pkg, rspve_cell, rspve_ram and the assertion macro header
`default_nettype none
`include "rs_parity_vector_encoder_core_assert.svh"
module rs_parity_vector_encoder_core #(
	parameter int MAX_PARITY = rspve_pkg::DEF_MAX_PARITY,
	parameter int MAX_VECTOR = rspve_pkg::DEF_MAX_VECTOR
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic                             cfg_addr,
	input  wire logic [rspve_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// byte_position[8:0], parity_select[12:9], data_byte[20:13], zero pad
	input  wire logic [rspve_pkg::IN_TDATA_W-1:0] s_tdata,
	// action[0]
	input  wire logic                             s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// parity_byte[7:0]
	output logic [7:0]                            m_tdata,
	// range_error[0]
	output logic                                  m_tuser
);
	import rspve_pkg::*;

	localparam int AW  = (MAX_VECTOR > 1) ? $clog2(MAX_VECTOR) : 1;
	localparam int PW  = (AW > POS_W) ? AW : POS_W;
	localparam int NPW = $clog2(MAX_PARITY + 1);
	localparam int VLW = $clog2(MAX_VECTOR + 1);

	state_t state_q, state_d;

	logic [NPW-1:0]  np_q;
	logic [VLW-1:0]  vlen_q;
	logic [NPW-1:0]  gen_cnt_q;
	logic [7:0]      root_q;
	logic            gen_busy;
	logic [AW-1:0]   clr_cnt_q;
	logic            clr_done;

	logic             act_q;
	logic [POS_W-1:0] pos_q;
	logic [SEL_W-1:0] sel_q;
	logic [7:0]       data_q;

	logic       out_valid_q;
	logic [7:0] out_par_q;
	logic       out_err_q;

	logic             accept;
	logic [PW-1:0]    pos_in_w;
	logic [PW-1:0]    pos_w;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic             rd_en;
	cell_ctl_t        ctl;
	logic             item_err;
	logic [7:0]       sel_par;
	logic [7:0]       coef_bus [MAX_PARITY+1];
	logic [7:0]       par_bus  [MAX_PARITY+1];

	int np_new;
	int vl_new;

	assign gen_busy = (gen_cnt_q != '0);
	assign clr_done = (clr_cnt_q == AW'(MAX_VECTOR - 1));
	assign accept   = s_tvalid && s_tready;
	assign pos_in_w = PW'(s_tdata[POS_W-1:0]);
	assign pos_w    = PW'(pos_q);
	assign rd_addr  = pos_in_w[AW-1:0];

	// clamp configuration values
	always_comb begin
		np_new = int'(cfg_wdata[4:0]);
		if (np_new < 1) np_new = 1;
		if (np_new > MAX_PARITY) np_new = MAX_PARITY;
		vl_new = int'(cfg_wdata);
		if (vl_new < 1) vl_new = 1;
		if (vl_new > MAX_VECTOR) vl_new = MAX_VECTOR;
	end

	// configuration registers and generator rebuild sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q      <= NPW'(1);
			vlen_q    <= VLW'(MAX_VECTOR);
			gen_cnt_q <= '0;
			root_q    <= 8'h02;
		end else begin
			if (gen_busy) begin
				gen_cnt_q <= gen_cnt_q - NPW'(1);
				root_q    <= xtime(root_q);
			end
			if (cfg_wen && cfg_addr == REG_NUM_PARITY) begin
				np_q      <= NPW'(np_new);
				gen_cnt_q <= NPW'(np_new);
				root_q    <= 8'h02;
			end
			if (cfg_wen && cfg_addr == REG_VECTOR_LENGTH) begin
				vlen_q <= VLW'(vl_new);
			end
		end
	end

	// state register and clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR && !clr_done) clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_done) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_EXEC;
			ST_EXEC:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// range check of the held request
	assign item_err = (32'(pos_q) >= 32'(vlen_q)) ||
	                  (act_q == ACT_READ && 32'(sel_q) >= 32'(np_q));

	// outputs of the state machine
	always_comb begin
		s_tready     = 1'b0;
		rd_en        = 1'b0;
		wr_addr      = pos_w[AW-1:0];
		ctl.op       = OP_NONE;
		ctl.sel      = sel_q;
		ctl.fb       = data_q ^ par_bus[0];
		ctl.root     = root_q;
		ctl.gen_init = cfg_wen && cfg_addr == REG_NUM_PARITY;
		ctl.gen_step = gen_busy;
		case (state_q)
			ST_CLEAR: begin
				wr_addr = clr_cnt_q;
				ctl.op  = OP_CLEAR;
			end
			ST_IDLE: begin
				s_tready = !gen_busy && (!out_valid_q || m_tready);
				rd_en    = 1'b1;
			end
			ST_EXEC: begin
				if (!item_err) ctl.op = (act_q == ACT_READ) ? OP_READ_CLEAR : OP_ENCODE;
			end
			default: ctl.op = OP_NONE;
		endcase
	end

	// request holding register
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= s_tuser;
			pos_q  <= s_tdata[POS_W-1:0];
			sel_q  <= s_tdata[POS_W +: SEL_W];
			data_q <= s_tdata[POS_W+SEL_W +: BYTE_W];
		end
	end

	// parity byte picked for a read
	always_comb begin
		sel_par = 8'h00;
		for (int i = 0; i < MAX_PARITY; i++) begin
			if (32'(sel_q) == i) sel_par = par_bus[i];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EXEC) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			out_err_q <= item_err;
			out_par_q <= (!item_err && act_q == ACT_READ) ? sel_par : 8'h00;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_par_q;
	assign m_tuser  = out_err_q;

	// chain of cells: coefficients pass up, parity bytes pass down
	assign coef_bus[0]          = 8'h01;
	assign par_bus[MAX_PARITY]  = 8'h00;

	for (genvar g = 0; g < MAX_PARITY; g++) begin : g_cell
		rspve_cell #(
			.IDX        (g),
			.MAX_VECTOR (MAX_VECTOR),
			.AW         (AW),
			.NPW        (NPW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.num_parity (np_q),
			.rd_en      (rd_en),
			.rd_addr    (rd_addr),
			.wr_addr    (wr_addr),
			.coef_in    (coef_bus[g]),
			.coef_out   (coef_bus[g+1]),
			.par_in     (par_bus[g+1]),
			.par_out    (par_bus[g])
		);
	end

	// checks
	`ASSERT_NEXT(a_accept_exec, clk, arst_n, s_tvalid && s_tready, state_q == ST_EXEC)
	`ASSERT_IMPLIES(a_no_accept_gen, clk, arst_n, gen_busy, !s_tready)
	`ASSERT_NEXT(a_exec_result, clk, arst_n, state_q == ST_EXEC, m_tvalid)
	`ASSERT_IMPLIES(a_no_accept_clear, clk, arst_n, state_q == ST_CLEAR, !s_tready)
endmodule
`default_nettype wire

// ----- rtl/rspve_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module rspve_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/rspve_cell.sv -----
// one parity cell: a row of parity bytes and one generator coefficient
// depends on rspve_pkg and rspve_ram
`default_nettype none
module rspve_cell #(
	parameter int IDX = 0,
	parameter int MAX_VECTOR = 512,
	parameter int AW = 9,
	parameter int NPW = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rspve_pkg::cell_ctl_t ctl,
	input  wire logic [NPW-1:0]       num_parity,
	input  wire logic                 rd_en,
	input  wire logic [AW-1:0]        rd_addr,
	input  wire logic [AW-1:0]        wr_addr,
	input  wire logic [7:0]           coef_in,
	output logic      [7:0]           coef_out,
	input  wire logic [7:0]           par_in,
	output logic      [7:0]           par_out
);
	import rspve_pkg::*;

	logic [7:0] coef_q;
	logic       we;
	logic [7:0] wdata;
	logic       active;
	logic       has_next;

	assign active   = 32'(IDX) < 32'(num_parity);
	assign has_next = 32'(IDX + 1) < 32'(num_parity);

	// generator coefficient, reversed order: cell IDX holds g[np-1-IDX]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= (IDX == 0) ? 8'h02 : 8'h00;
		end else if (ctl.gen_init) begin
			coef_q <= 8'h00;
		end else if (ctl.gen_step) begin
			coef_q <= coef_q ^ gf_mul(ctl.root, coef_in);
		end
	end
	assign coef_out = coef_q;

	// parity row write
	always_comb begin
		we    = 1'b0;
		wdata = 8'h00;
		case (ctl.op)
			OP_CLEAR: we = 1'b1;
			OP_ENCODE: begin
				we    = active;
				wdata = (has_next ? par_in : 8'h00) ^ gf_mul(coef_q, ctl.fb);
			end
			OP_READ_CLEAR: we = (32'(ctl.sel) == 32'(IDX));
			default: we = 1'b0;
		endcase
	end

	rspve_ram #(.WIDTH(8), .DEPTH(MAX_VECTOR), .AW(AW)) u_row (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (par_out)
	);
endmodule
`default_nettype wire
